>>> rtl/bitmap_page_frame_allocator_core_assert.svh
// Assertion macros for the checker file of the page frame allocator.
`ifndef BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH
`define BITMAP_PAGE_FRAME_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, sampled on clk and quiet while rst_n is low.
`define BPFA_ASSERT_IMM(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk and quiet while rst_n is low.
`define BPFA_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bpfa_pkg.sv
`timescale 1ns / 1ps

package bpfa_pkg;

  // Field widths of the request, result and configuration port.
  localparam int OP_W       = 2;
  localparam int ADDR_W     = 32;
  localparam int CNT_W      = 16;
  localparam int ST_W       = 3;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  // Register indexes and their reset values.
  localparam logic [CFG_IDX_W-1:0]  CFG_PAGE_TOTAL     = 1'b0;
  localparam logic [CFG_IDX_W-1:0]  CFG_RESERVED_PAGES = 1'b1;
  localparam logic [CFG_DATA_W-1:0] PAGE_TOTAL_RST     = 16'd32768;
  localparam logic [CFG_DATA_W-1:0] RESERVED_PAGES_RST = 16'd513;

  typedef enum logic [OP_W-1:0] {
    OP_INIT  = 2'd0,
    OP_ALLOC = 2'd1,
    OP_FREE  = 2'd2,
    OP_QUERY = 2'd3
  } op_t;

  typedef enum logic [ST_W-1:0] {
    ST_OK       = 3'd0,
    ST_NOINIT   = 3'd1,
    ST_NOMEM    = 3'd2,
    ST_INVALID  = 3'd3,
    ST_DOUBLE   = 3'd4,
    ST_IGNORED  = 3'd5,
    ST_BADCOUNT = 3'd6
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_ASCAN,
    S_ACHK,
    S_FCHK,
    S_RESP
  } state_t;

endpackage

>>> rtl/bpfa_if.sv
`timescale 1ns / 1ps

// Request channel: one allocator command per transfer.
interface bpfa_req_if;
  logic                         valid;
  logic                         ready;
  logic [bpfa_pkg::OP_W-1:0]    op;
  logic [bpfa_pkg::ADDR_W-1:0]  frame_address;
  logic [bpfa_pkg::CNT_W-1:0]   page_count;

  modport source (output valid, op, frame_address, page_count, input ready);
  modport sink   (input valid, op, frame_address, page_count, output ready);
endinterface

// Result channel: one status and count report per request.
interface bpfa_rsp_if;
  logic                         valid;
  logic                         ready;
  logic [bpfa_pkg::ST_W-1:0]    status;
  logic [bpfa_pkg::ADDR_W-1:0]  alloc_address;
  logic [bpfa_pkg::CNT_W-1:0]   free_count;
  logic [bpfa_pkg::CNT_W-1:0]   used_count;

  modport source (output valid, status, alloc_address, free_count, used_count, input ready);
  modport sink   (input valid, status, alloc_address, free_count, used_count, output ready);
endinterface

>>> rtl/bpfa_ram.sv
`timescale 1ns / 1ps

// Simple dual-port RAM: one write and one read per cycle, registered read data.
module bpfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                                    clk,
  input  logic                                    we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                        wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                        rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/bitmap_page_frame_allocator_core.sv
`timescale 1ns / 1ps

// Channel   Direction  Transfers                     Payload
// in_ch     sink       one request per command       op, frame_address, page_count
// out_ch    source     one result per request        status, alloc_address, counts
// cfg_*     write      register write, no handshake  page total, reserved run
//
// Query and rejected requests go from decode to the result state; free first reads
// and checks its map word (S_FCHK). Allocate reads words from a first-free word hint,
// passing over full ones (S_ASCAN, S_ACHK). Init: one map word written per cycle.
// The map RAM is read once and written once per cycle; one request is in flight.
// Reset clears control state only; the map is rebuilt by every init request.
// A stalled result holds in the output register; a new request is still accepted.
module bitmap_page_frame_allocator_core #(
  parameter int MAX_PAGES     = 32768,
  parameter int PAGE_BYTES    = 4096,
  parameter int MAP_WORD_BITS = 32
) (
  input  logic                              clk,
  input  logic                              rst_n,
  bpfa_req_if.sink                          in_ch,
  bpfa_rsp_if.source                        out_ch,
  input  logic                              cfg_we,
  input  logic [bpfa_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [bpfa_pkg::CFG_DATA_W-1:0]   cfg_wdata
);

  // Map geometry; word and page sizes are powers of two.
  localparam int MAP_WORDS = (MAX_PAGES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
  localparam int WB        = $clog2(MAP_WORD_BITS);
  localparam int PB        = $clog2(PAGE_BYTES);
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int HW        = $clog2(MAP_WORDS + 1);
  localparam int PW        = AW + WB;
  localparam int CMP_W     = (HW + WB > bpfa_pkg::CNT_W) ? HW + WB : bpfa_pkg::CNT_W;
  localparam int CW        = bpfa_pkg::CNT_W;
  localparam int AD        = bpfa_pkg::ADDR_W;

  localparam logic [MAP_WORD_BITS-1:0] ONES = {MAP_WORD_BITS{1'b1}};

  bpfa_pkg::state_t  state_r, state_nxt;
  bpfa_pkg::status_t stat_r, stat_nxt;

  logic [CW-1:0]  cfg_total_r, cfg_res_r;
  logic [CW-1:0]  active_r, active_nxt;
  logic [CW-1:0]  free_r, free_nxt;
  logic [CW-1:0]  res_r, res_nxt;
  logic           ready_r, ready_nxt;
  logic [HW-1:0]  hint_r, hint_nxt;
  logic [HW-1:0]  scan_r, scan_nxt;
  logic [AW-1:0]  sweep_r, sweep_nxt;
  logic [AW-1:0]  fword_r, fword_nxt;
  logic [WB-1:0]  fbit_r, fbit_nxt;
  logic [AD-1:0]  aaddr_r, aaddr_nxt;

  logic                           out_valid_r, out_valid_nxt;
  logic [bpfa_pkg::ST_W-1:0]      out_status_r, out_status_nxt;
  logic [AD-1:0]                  out_aaddr_r, out_aaddr_nxt;
  logic [CW-1:0]                  out_free_r, out_free_nxt;
  logic [CW-1:0]                  out_used_r, out_used_nxt;

  logic                     mem_we;
  logic [AW-1:0]            mem_waddr, mem_raddr;
  logic [MAP_WORD_BITS-1:0] mem_wdata, mem_rdata;

  logic                     in_ready_c;
  logic [CW-1:0]            total_clamp, res_clamp;
  logic [AD-1:0]            req_page;
  logic [CMP_W-1:0]         scan_base, sweep_base, res_ext, nbits_full;
  logic                     scan_end;
  logic [MAP_WORD_BITS-1:0] init_word, low_zero, bit_mask;
  logic [WB-1:0]            low_idx;
  logic [PW-1:0]            alloc_page;
  logic                     alloc_beyond;

  // Used map storage.
  bpfa_ram #(
    .WIDTH (MAP_WORD_BITS),
    .DEPTH (MAP_WORDS)
  ) u_map (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // Init bounds: total clamped to the map size, reserved run clamped to the total.
  assign total_clamp = (32'(cfg_total_r) > 32'(MAX_PAGES)) ? CW'(MAX_PAGES) : cfg_total_r;
  assign res_clamp   = (cfg_res_r < total_clamp) ? cfg_res_r : total_clamp;

  // Page that holds the byte address of a free request.
  assign req_page = in_ch.frame_address >> PB;

  // Scan limit: a word that starts at or above the total holds no usable page.
  assign scan_base = CMP_W'(scan_r) << WB;
  assign scan_end  = scan_base >= CMP_W'(active_r);

  // Init word: all ones below the reserved run, a partial mask across its end.
  assign sweep_base = CMP_W'(sweep_r) << WB;
  assign res_ext    = CMP_W'(res_r);
  assign nbits_full = res_ext - sweep_base;

  always_comb begin
    if (res_ext >= sweep_base + CMP_W'(MAP_WORD_BITS)) begin
      init_word = ONES;
    end else if (res_ext <= sweep_base) begin
      init_word = '0;
    end else begin
      init_word = ~(ONES << nbits_full[WB-1:0]);
    end
  end

  // Lowest clear bit of the word read back, isolated and then encoded.
  assign low_zero = ~mem_rdata & (mem_rdata + MAP_WORD_BITS'(1));

  always_comb begin
    low_idx = '0;
    for (int j = 0; j < MAP_WORD_BITS; j++) begin
      for (int k = 0; k < WB; k++) begin
        if (j[k]) begin
          low_idx[k] = low_idx[k] | low_zero[j];
        end
      end
    end
  end

  assign alloc_page   = {scan_r[AW-1:0], low_idx};
  assign alloc_beyond = CMP_W'(alloc_page) >= CMP_W'(active_r);
  assign bit_mask     = MAP_WORD_BITS'(1) << fbit_r;

  // Sequencer: decode, map read-modify-write, init sweep and result hand-off.
  always_comb begin
    state_nxt      = state_r;
    stat_nxt       = stat_r;
    active_nxt     = active_r;
    free_nxt       = free_r;
    res_nxt        = res_r;
    ready_nxt      = ready_r;
    hint_nxt       = hint_r;
    scan_nxt       = scan_r;
    sweep_nxt      = sweep_r;
    fword_nxt      = fword_r;
    fbit_nxt       = fbit_r;
    aaddr_nxt      = aaddr_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_status_nxt = out_status_r;
    out_aaddr_nxt  = out_aaddr_r;
    out_free_nxt   = out_free_r;
    out_used_nxt   = out_used_r;
    mem_we         = 1'b0;
    mem_waddr      = sweep_r;
    mem_wdata      = init_word;
    mem_raddr      = scan_r[AW-1:0];
    in_ready_c     = 1'b0;

    case (state_r)
      bpfa_pkg::S_IDLE: begin
        in_ready_c = 1'b1;
        if (in_ch.valid) begin
          aaddr_nxt = '0;
          stat_nxt  = bpfa_pkg::ST_OK;
          state_nxt = bpfa_pkg::S_RESP;
          case (bpfa_pkg::op_t'(in_ch.op))
            bpfa_pkg::OP_INIT: begin
              active_nxt = total_clamp;
              res_nxt    = res_clamp;
              free_nxt   = total_clamp - res_clamp;
              hint_nxt   = HW'(res_clamp >> WB);
              ready_nxt  = 1'b1;
              sweep_nxt  = '0;
              state_nxt  = bpfa_pkg::S_INIT;
            end
            bpfa_pkg::OP_ALLOC: begin
              if (!ready_r) begin
                stat_nxt = bpfa_pkg::ST_NOINIT;
              end else if (free_r == '0) begin
                stat_nxt = bpfa_pkg::ST_NOMEM;
              end else if (in_ch.page_count == '0 || in_ch.page_count > free_r) begin
                stat_nxt = bpfa_pkg::ST_BADCOUNT;
              end else begin
                scan_nxt  = hint_r;
                state_nxt = bpfa_pkg::S_ASCAN;
              end
            end
            bpfa_pkg::OP_FREE: begin
              if (!ready_r) begin
                stat_nxt = bpfa_pkg::ST_NOINIT;
              end else if (in_ch.frame_address == '0) begin
                stat_nxt = bpfa_pkg::ST_IGNORED;
              end else if (req_page >= AD'(active_r)) begin
                stat_nxt = bpfa_pkg::ST_INVALID;
              end else begin
                fword_nxt = req_page[PW-1:WB];
                fbit_nxt  = req_page[WB-1:0];
                mem_raddr = req_page[PW-1:WB];
                state_nxt = bpfa_pkg::S_FCHK;
              end
            end
            bpfa_pkg::OP_QUERY: begin
              stat_nxt = bpfa_pkg::ST_OK;
            end
            default: begin
              stat_nxt = bpfa_pkg::ST_OK;
            end
          endcase
        end
      end

      // One map word per cycle: reserved run set, everything else cleared.
      bpfa_pkg::S_INIT: begin
        mem_we    = 1'b1;
        mem_waddr = sweep_r;
        mem_wdata = init_word;
        if (sweep_r == AW'(MAP_WORDS - 1)) begin
          state_nxt = bpfa_pkg::S_RESP;
        end else begin
          sweep_nxt = sweep_r + AW'(1);
        end
      end

      // Issue the read of the next candidate word, or give up past the total.
      bpfa_pkg::S_ASCAN: begin
        if (scan_end) begin
          stat_nxt  = bpfa_pkg::ST_NOMEM;
          state_nxt = bpfa_pkg::S_RESP;
        end else begin
          mem_raddr = scan_r[AW-1:0];
          state_nxt = bpfa_pkg::S_ACHK;
        end
      end

      // Full words move the hint on; otherwise take the lowest clear page, or no memory past the total.
      bpfa_pkg::S_ACHK: begin
        if (&mem_rdata) begin
          scan_nxt  = scan_r + HW'(1);
          hint_nxt  = scan_r + HW'(1);
          state_nxt = bpfa_pkg::S_ASCAN;
        end else if (alloc_beyond) begin
          stat_nxt  = bpfa_pkg::ST_NOMEM;
          state_nxt = bpfa_pkg::S_RESP;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = scan_r[AW-1:0];
          mem_wdata = mem_rdata | low_zero;
          free_nxt  = free_r - CW'(1);
          aaddr_nxt = AD'(alloc_page) << PB;
          stat_nxt  = bpfa_pkg::ST_OK;
          state_nxt = bpfa_pkg::S_RESP;
        end
      end

      // Clear a used page; a clear page is a double free.
      bpfa_pkg::S_FCHK: begin
        if (!mem_rdata[fbit_r]) begin
          stat_nxt = bpfa_pkg::ST_DOUBLE;
        end else begin
          mem_we    = 1'b1;
          mem_waddr = fword_r;
          mem_wdata = mem_rdata & ~bit_mask;
          free_nxt  = free_r + CW'(1);
          stat_nxt  = bpfa_pkg::ST_OK;
          if (HW'(fword_r) < hint_r) begin
            hint_nxt = HW'(fword_r);
          end
        end
        state_nxt = bpfa_pkg::S_RESP;
      end

      // Move the result into the output register once it is free.
      bpfa_pkg::S_RESP: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt  = 1'b1;
          out_status_nxt = stat_r;
          out_aaddr_nxt  = aaddr_r;
          out_free_nxt   = free_r;
          out_used_nxt   = active_r - free_r;
          state_nxt      = bpfa_pkg::S_IDLE;
        end
      end

      default: begin
        state_nxt = bpfa_pkg::S_IDLE;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= bpfa_pkg::S_IDLE;
      out_valid_r <= 1'b0;
      ready_r     <= 1'b0;
      active_r    <= '0;
      free_r      <= '0;
      hint_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      ready_r     <= ready_nxt;
      active_r    <= active_nxt;
      free_r      <= free_nxt;
      hint_r      <= hint_nxt;
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_total_r <= bpfa_pkg::PAGE_TOTAL_RST;
      cfg_res_r   <= bpfa_pkg::RESERVED_PAGES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        bpfa_pkg::CFG_PAGE_TOTAL:     cfg_total_r <= cfg_wdata;
        bpfa_pkg::CFG_RESERVED_PAGES: cfg_res_r   <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Working and result payload registers.
  always_ff @(posedge clk) begin
    stat_r       <= stat_nxt;
    res_r        <= res_nxt;
    scan_r       <= scan_nxt;
    sweep_r      <= sweep_nxt;
    fword_r      <= fword_nxt;
    fbit_r       <= fbit_nxt;
    aaddr_r      <= aaddr_nxt;
    out_status_r <= out_status_nxt;
    out_aaddr_r  <= out_aaddr_nxt;
    out_free_r   <= out_free_nxt;
    out_used_r   <= out_used_nxt;
  end

  assign in_ch.ready          = in_ready_c;
  assign out_ch.valid         = out_valid_r;
  assign out_ch.status        = out_status_r;
  assign out_ch.alloc_address = out_aaddr_r;
  assign out_ch.free_count    = out_free_r;
  assign out_ch.used_count    = out_used_r;

endmodule

>>> rtl/bpfa_checker.sv
`timescale 1ns / 1ps
`include "bitmap_page_frame_allocator_core_assert.svh"

// Port-level checks on the allocator's request and result channels.
module bpfa_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [bpfa_pkg::ST_W-1:0]       out_status,
  input logic [bpfa_pkg::ADDR_W-1:0]     out_alloc_address,
  input logic [bpfa_pkg::CNT_W-1:0]      out_free_count,
  input logic [bpfa_pkg::CNT_W-1:0]      out_used_count
);

  // A stalled result stays valid.
  `BPFA_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid, "result dropped while stalled")

  // A stalled result keeps its payload.
  `BPFA_ASSERT_NXT(a_out_stable, out_valid && !out_ready, $stable(out_status) && $stable(out_alloc_address) && $stable(out_free_count) && $stable(out_used_count), "result changed while stalled")

  // Only one request is in flight: acceptance closes the request channel.
  `BPFA_ASSERT_NXT(a_one_in_flight, in_valid && in_ready, !in_ready, "second request accepted while busy")

  // Results with an error status carry a null address.
  `BPFA_ASSERT_IMM(a_null_on_fail, out_valid && out_status != bpfa_pkg::ST_OK, out_alloc_address == '0, "address reported with error status")

endmodule

bind bitmap_page_frame_allocator_core bpfa_checker u_bpfa_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .in_valid          (in_ch.valid),
  .in_ready          (in_ch.ready),
  .out_valid         (out_ch.valid),
  .out_ready         (out_ch.ready),
  .out_status        (out_ch.status),
  .out_alloc_address (out_ch.alloc_address),
  .out_free_count    (out_ch.free_count),
  .out_used_count    (out_ch.used_count)
);
